### rtl/sobnms_pkg.sv
// Shared types and constants for the Sobel, peak and threshold edge unit.
package sobnms_pkg;

    localparam int PIX_W     = 8;
    localparam int MAG_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 4;
    localparam int GRAD_W    = 11;
    localparam int AX_W      = 10;
    localparam int SQ_W      = 21;
    localparam int ROOT_W    = 22;
    localparam int TAN_W     = 18;
    localparam int PROD_W    = 28;
    localparam int SEC_W     = 2;
    localparam int CLASS_W   = 2;

    localparam logic [TAN_W-1:0] TAN_A_POS = 18'd25815;
    localparam logic [TAN_W-1:0] TAN_B_POS = 18'd150722;
    localparam logic [TAN_W-1:0] TAN_A_NEG = 18'd28496;
    localparam logic [TAN_W-1:0] TAN_B_NEG = 18'd166373;

    localparam logic [SQ_W-1:0] ROOT_START = 21'h100000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_WIDTH    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_HEIGHT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW_THRESHOLD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGH_THRESHOLD = 4'd3;

    localparam logic [SEC_W-1:0] SEC_HORZ     = 2'd0;
    localparam logic [SEC_W-1:0] SEC_DIAG_POS = 2'd1;
    localparam logic [SEC_W-1:0] SEC_VERT     = 2'd2;
    localparam logic [SEC_W-1:0] SEC_DIAG_NEG = 2'd3;

    localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] gray_pixel;
    } in_word_t;

    typedef struct packed {
        logic               edge_peak;
        logic [CLASS_W-1:0] edge_class;
        logic [MAG_W-1:0]   gradient_magnitude;
        logic               frame_last;
    } out_word_t;

    typedef struct packed {
        logic             pix_en;
        logic             mag_en;
        logic             mag_inner;
        logic             res_en;
        logic             res_inner;
        logic             res_last;
        logic [PIX_W-1:0] pixel;
    } step_ctl_t;

    typedef enum logic {
        FR_RUN,
        FR_DIV
    } front_state_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_PIX,
        BK_GRAD,
        BK_MULX,
        BK_MULY,
        BK_TANA,
        BK_TANB,
        BK_ROOT,
        BK_ROUND,
        BK_MAG,
        BK_OUT
    } back_state_t;

endpackage

### rtl/sobnms_fifo.sv
// Two-entry queue between the position front end and the compute back end.
module sobnms_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    logic [DATA_W-1:0] data_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### rtl/sobnms_front.sv
// Front end: raster position tracking and per-word stage control.
module sobnms_front import sobnms_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  in_word_t                             in_data,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       frame_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      frame_h,
    input  logic                                 resync,
    input  logic                                 hold,
    input  logic                                 full,
    output logic                                 push,
    output step_ctl_t                            push_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]         push_col,
    output logic [$clog2(MAX_WIDTH)-1:0]         push_mcol
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
    localparam int NW = $clog2(PW + 1);

    front_state_t   state_reg, state_next;
    logic [PW-1:0]  p_reg, row_reg, dvd_reg;
    logic [CW-1:0]  col_reg;
    logic [NW-1:0]  cnt_reg;

    logic [PW-1:0]  h_ext, h_plus2, row_e, row1, row2, k1, k2;
    logic [CW-1:0]  col_e, col1, col2, col_inc;
    logic           wrap, c0, c1, b_ok, c_ok, col_wrap, at_end;
    logic           mag_en, res_en;
    logic [CW:0]    trial;
    logic           ge;

    assign h_ext   = PW'(frame_h);
    assign h_plus2 = h_ext + PW'(2);
    assign wrap    = (row_reg > h_plus2) || (row_reg == h_plus2 && col_reg >= CW'(2));
    assign row_e   = wrap ? '0 : row_reg;
    assign col_e   = wrap ? '0 : col_reg;
    assign c0      = (col_e == '0);
    assign c1      = (col_e < CW'(2));
    assign k1      = c0 ? PW'(2) : PW'(1);
    assign k2      = c1 ? PW'(3) : PW'(2);
    assign b_ok    = (row_e >= k1);
    assign c_ok    = (row_e >= k2);
    assign row1    = row_e - k1;
    assign row2    = row_e - k2;
    assign col1    = c0 ? frame_w - CW'(1) : col_e - CW'(1);
    assign col2    = c1 ? col_e + frame_w - CW'(2) : col_e - CW'(2);
    assign mag_en  = b_ok && (row1 < h_ext);
    assign res_en  = c_ok && (row2 < h_ext);
    assign col_inc = col_e + CW'(1);
    assign col_wrap = (col_inc == frame_w);
    assign at_end  = (row_e == h_plus2) && (col_e == CW'(1));

    assign trial = {col_reg, dvd_reg[PW-1]};
    assign ge    = (trial >= {1'b0, frame_w});

    always_comb
    begin
        push_ctl.pix_en    = (row_e < h_ext);
        push_ctl.mag_en    = mag_en;
        push_ctl.mag_inner = mag_en && (row1 >= PW'(1)) && (row1 <= h_ext - PW'(2))
                             && (col1 >= CW'(1)) && (col1 <= frame_w - CW'(2));
        push_ctl.res_en    = res_en;
        push_ctl.res_inner = res_en && (row2 >= PW'(1)) && (row2 <= h_ext - PW'(2))
                             && (col2 >= CW'(1)) && (col2 <= frame_w - CW'(2));
        push_ctl.res_last  = res_en && (row2 == h_ext - PW'(1))
                             && (col2 == frame_w - CW'(1));
        push_ctl.pixel     = in_data.action ? '0 : in_data.gray_pixel;
        push_col           = col_e[AW-1:0];
        push_mcol          = col1[AW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_RUN:
            begin
                if (resync)
                begin
                    state_next = FR_DIV;
                end
            end
            FR_DIV:
            begin
                if (!resync && cnt_reg == NW'(1))
                begin
                    state_next = FR_RUN;
                end
            end
            default: state_next = FR_RUN;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == FR_RUN) && !full && !hold && !resync;
        push     = in_valid && in_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_RUN;
            p_reg     <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            dvd_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (resync)
            begin
                dvd_reg <= p_reg;
                row_reg <= '0;
                col_reg <= '0;
                cnt_reg <= NW'(PW);
            end
            else if (state_reg == FR_DIV)
            begin
                col_reg <= ge ? CW'(trial - {1'b0, frame_w}) : trial[CW-1:0];
                row_reg <= {row_reg[PW-2:0], ge};
                dvd_reg <= {dvd_reg[PW-2:0], 1'b0};
                cnt_reg <= cnt_reg - NW'(1);
            end
            else if (push)
            begin
                if (at_end)
                begin
                    p_reg   <= '0;
                    row_reg <= '0;
                    col_reg <= '0;
                end
                else
                begin
                    p_reg   <= wrap ? PW'(1) : p_reg + PW'(1);
                    col_reg <= col_wrap ? '0 : col_inc;
                    row_reg <= row_e + PW'(col_wrap);
                end
            end
        end
    end

endmodule

### rtl/sobnms_back.sv
// Back end: line stores, Sobel gradient, root, sector, peak test and result word.
module sobnms_back import sobnms_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         empty,
    input  step_ctl_t                    head_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0] head_col,
    input  logic [$clog2(MAX_WIDTH)-1:0] head_mcol,
    output logic                         pop,
    output logic                         clearing,
    input  logic [CFG_W-1:0]             low_thr,
    input  logic [CFG_W-1:0]             high_thr,
    output logic                         out_valid,
    input  logic                         out_ready,
    output out_word_t                    out_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    back_state_t state_reg, state_next;
    logic [AW-1:0] clr_reg;
    step_ctl_t     ctl_reg;
    logic [AW-1:0] col_reg, mcol_reg;

    logic [PIX_W-1:0] ptop_mem [MAX_WIDTH];
    logic [PIX_W-1:0] pmid_mem [MAX_WIDTH];
    logic [MAG_W-1:0] mtop_mem [MAX_WIDTH];
    logic [MAG_W-1:0] mmid_mem [MAX_WIDTH];
    logic [SEC_W-1:0] sec_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] ptop_rd, pmid_rd;
    logic [MAG_W-1:0] mtop_rd, mmid_rd;
    logic [SEC_W-1:0] sec_rd;

    logic [PIX_W-1:0] pwin_reg [9];
    logic [MAG_W-1:0] mwin_reg [9];

    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [AX_W-1:0]   ax_reg, ay_reg;
    logic [SQ_W-1:0]   sq_reg, rem_reg, bit_reg;
    logic [ROOT_W-1:0] f_reg;
    logic [PROD_W-1:0] proda_reg, prodb_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [SEC_W-1:0]  sec_reg, sec_delay_reg, center_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    logic              pix_we, mag_we, out_load;
    logic [AW-1:0]     pix_wa, mag_wa;
    logic [PIX_W-1:0]  ptop_wd, pmid_wd;
    logic [MAG_W-1:0]  mtop_wd, mmid_wd;
    logic [SEC_W-1:0]  sec_wd;

    logic signed [GRAD_W-1:0] gx_c, gy_c;
    logic [AX_W-1:0]   ax_c, ay_c;
    logic [TAN_W-1:0]  tan_a, tan_b;
    logic [ROOT_W-1:0] trial;
    logic              take;
    logic [PROD_W-1:0] lhs;
    logic [SEC_W-1:0]  sec_c, diag;
    logic [MAG_W-1:0]  root_c;
    logic [MAG_W-1:0]  g_c, na_c, nb_c;
    out_word_t         res_c;

    assign gx_c = GRAD_W'((int'(pwin_reg[2]) - int'(pwin_reg[0]))
                  + 2 * (int'(pwin_reg[5]) - int'(pwin_reg[3]))
                  + (int'(pwin_reg[8]) - int'(pwin_reg[6])));
    assign gy_c = GRAD_W'((int'(pwin_reg[6]) + 2 * int'(pwin_reg[7]) + int'(pwin_reg[8]))
                  - (int'(pwin_reg[0]) + 2 * int'(pwin_reg[1]) + int'(pwin_reg[2])));
    assign ax_c = gx_c[GRAD_W-1] ? AX_W'(-gx_c) : AX_W'(gx_c);
    assign ay_c = gy_c[GRAD_W-1] ? AX_W'(-gy_c) : AX_W'(gy_c);

    assign tan_a = gx_reg[GRAD_W-1] ? TAN_A_NEG : TAN_A_POS;
    assign tan_b = gx_reg[GRAD_W-1] ? TAN_B_NEG : TAN_B_POS;

    assign trial = f_reg + ROOT_W'(bit_reg);
    assign take  = ({1'b0, rem_reg} >= trial);
    assign root_c = MAG_W'(f_reg + ROOT_W'(ROOT_W'(rem_reg) > f_reg));

    assign lhs  = PROD_W'({ay_reg, 16'h0000});
    assign diag = (gx_reg[GRAD_W-1] == gy_reg[GRAD_W-1]) ? SEC_DIAG_POS : SEC_DIAG_NEG;

    always_comb
    begin
        if (ax_reg == '0 && ay_reg == '0)
        begin
            sec_c = SEC_HORZ;
        end
        else if (!gx_reg[GRAD_W-1])
        begin
            sec_c = (lhs < proda_reg) ? SEC_HORZ : ((lhs < prodb_reg) ? diag : SEC_VERT);
        end
        else
        begin
            sec_c = (lhs <= proda_reg) ? SEC_HORZ : ((lhs <= prodb_reg) ? diag : SEC_VERT);
        end
    end

    always_comb
    begin
        case (center_reg)
            SEC_HORZ:
            begin
                na_c = mwin_reg[3];
                nb_c = mwin_reg[5];
            end
            SEC_DIAG_POS:
            begin
                na_c = mwin_reg[2];
                nb_c = mwin_reg[6];
            end
            SEC_VERT:
            begin
                na_c = mwin_reg[1];
                nb_c = mwin_reg[7];
            end
            default:
            begin
                na_c = mwin_reg[0];
                nb_c = mwin_reg[8];
            end
        endcase
        g_c                      = ctl_reg.res_inner ? mwin_reg[4] : '0;
        res_c.edge_peak          = ctl_reg.res_inner && (g_c >= na_c) && (g_c >= nb_c);
        res_c.gradient_magnitude = g_c;
        res_c.frame_last         = ctl_reg.res_last;
        if (g_c >= high_thr)
        begin
            res_c.edge_class = CLASS_STRONG;
        end
        else if (g_c < low_thr)
        begin
            res_c.edge_class = CLASS_NONE;
        end
        else
        begin
            res_c.edge_class = CLASS_WEAK;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR: if (clr_reg == AW'(MAX_WIDTH - 1)) state_next = BK_IDLE;
            BK_IDLE:  if (!empty) state_next = BK_READ;
            BK_READ:  state_next = BK_PIX;
            BK_PIX:   state_next = BK_GRAD;
            BK_GRAD:  state_next = BK_MULX;
            BK_MULX:  state_next = BK_MULY;
            BK_MULY:  state_next = BK_TANA;
            BK_TANA:  state_next = BK_TANB;
            BK_TANB:  state_next = BK_ROOT;
            BK_ROOT:  if (bit_reg[0]) state_next = BK_ROUND;
            BK_ROUND: state_next = BK_MAG;
            BK_MAG:   state_next = BK_OUT;
            BK_OUT:
            begin
                if (!ctl_reg.res_en || !out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        clearing = (state_reg == BK_CLEAR);
        pop      = (state_reg == BK_IDLE) && !empty;
        pix_we   = clearing || ((state_reg == BK_PIX) && ctl_reg.pix_en);
        mag_we   = clearing || ((state_reg == BK_MAG) && ctl_reg.mag_en);
        pix_wa   = clearing ? clr_reg : col_reg;
        mag_wa   = clearing ? clr_reg : mcol_reg;
        ptop_wd  = clearing ? '0 : pmid_rd;
        pmid_wd  = clearing ? '0 : ctl_reg.pixel;
        mtop_wd  = clearing ? '0 : mmid_rd;
        mmid_wd  = clearing ? '0 : mag_reg;
        sec_wd   = clearing ? SEC_HORZ : sec_reg;
        out_load = (state_reg == BK_OUT) && ctl_reg.res_en && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            ptop_mem[pix_wa] <= ptop_wd;
            pmid_mem[pix_wa] <= pmid_wd;
        end
        ptop_rd <= ptop_mem[col_reg];
        pmid_rd <= pmid_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mag_we)
        begin
            mtop_mem[mag_wa] <= mtop_wd;
            mmid_mem[mag_wa] <= mmid_wd;
            sec_mem[mag_wa]  <= sec_wd;
        end
        mtop_rd <= mtop_mem[mcol_reg];
        mmid_rd <= mmid_mem[mcol_reg];
        sec_rd  <= sec_mem[mcol_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ctl_reg  <= head_ctl;
            col_reg  <= head_col;
            mcol_reg <= head_mcol;
        end
        if (state_reg == BK_GRAD)
        begin
            gx_reg <= gx_c;
            gy_reg <= gy_c;
            ax_reg <= ax_c;
            ay_reg <= ay_c;
        end
        if (state_reg == BK_MULX)
        begin
            sq_reg <= {{(SQ_W-AX_W){1'b0}}, ax_reg} * {{(SQ_W-AX_W){1'b0}}, ax_reg};
        end
        if (state_reg == BK_MULY)
        begin
            sq_reg <= sq_reg + {{(SQ_W-AX_W){1'b0}}, ay_reg} * {{(SQ_W-AX_W){1'b0}}, ay_reg};
        end
        if (state_reg == BK_TANA)
        begin
            proda_reg <= {{(PROD_W-AX_W){1'b0}}, ax_reg} * {{(PROD_W-TAN_W){1'b0}}, tan_a};
        end
        if (state_reg == BK_TANB)
        begin
            prodb_reg <= {{(PROD_W-AX_W){1'b0}}, ax_reg} * {{(PROD_W-TAN_W){1'b0}}, tan_b};
            rem_reg   <= sq_reg;
            f_reg     <= '0;
            bit_reg   <= ROOT_START;
        end
        if (state_reg == BK_ROOT)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - SQ_W'(trial);
                f_reg   <= (f_reg >> 1) + ROOT_W'(bit_reg);
            end
            else
            begin
                f_reg <= f_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == BK_ROUND)
        begin
            mag_reg <= ctl_reg.mag_inner ? root_c : '0;
            sec_reg <= ctl_reg.mag_inner ? sec_c : SEC_HORZ;
        end
        if (out_load)
        begin
            out_word_reg <= res_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            sec_delay_reg <= SEC_HORZ;
            center_reg    <= SEC_HORZ;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                pwin_reg[i] <= '0;
                mwin_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == BK_PIX && ctl_reg.pix_en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pwin_reg[i*3]   <= pwin_reg[i*3+1];
                    pwin_reg[i*3+1] <= pwin_reg[i*3+2];
                end
                pwin_reg[2] <= ptop_rd;
                pwin_reg[5] <= pmid_rd;
                pwin_reg[8] <= ctl_reg.pixel;
            end
            if (state_reg == BK_MAG)
            begin
                center_reg <= sec_delay_reg;
                if (ctl_reg.mag_en)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mwin_reg[i*3]   <= mwin_reg[i*3+1];
                        mwin_reg[i*3+1] <= mwin_reg[i*3+2];
                    end
                    mwin_reg[2]   <= mtop_rd;
                    mwin_reg[5]   <= mmid_rd;
                    mwin_reg[8]   <= mag_reg;
                    sec_delay_reg <= sec_rd;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

`ifndef SYNTHESIS
    a_root_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_ROOT |-> $onehot(bit_reg))
        else $error("root step bit not one-hot");
    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == BK_OUT))
        else $error("result word raised outside output step");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_CLEAR |-> !pop)
        else $error("queue popped during store clear");
`endif

endmodule

### rtl/sobel_nms_double_threshold_unit.sv
// Top level: configuration registers, front end, queue and back end.
// The back end takes one queued word at a time; its 11-step square root sets the pace.
// Each accepted word gives at most one result word, which waits for out_ready;
// the result for a pixel comes with the word 2*W+2 positions later (W = clamped frame width).
// Width writes stall input while the row/column counters re-divide.
// After reset the line stores are cleared at all MAX_WIDTH addresses; input waits until done.
// Reset restores register defaults 1024, 768, 125, 225 and zeroes all windows.
module sobel_nms_double_threshold_unit import sobnms_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_word_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int DW = $bits(step_ctl_t) + 2 * AW;

    logic [CFG_W-1:0] width_reg, height_reg, low_reg, high_reg;
    logic [CW-1:0]    frame_w;
    logic [RW-1:0]    frame_h;
    logic             resync;

    logic             push, pop, full, empty, clearing;
    step_ctl_t        push_ctl, head_ctl;
    logic [AW-1:0]    push_col, push_mcol, head_col, head_mcol;
    logic [DW-1:0]    head_data;

    assign cfg_ready = 1'b1;
    assign resync    = cfg_valid && (cfg_index == CFG_IDX_FRAME_WIDTH);

    always_comb
    begin
        if (width_reg < CFG_W'(3))
        begin
            frame_w = CW'(3);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            frame_w = CW'(MAX_WIDTH);
        end
        else
        begin
            frame_w = CW'(width_reg);
        end
        if (height_reg < CFG_W'(3))
        begin
            frame_h = RW'(3);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            frame_h = RW'(MAX_HEIGHT);
        end
        else
        begin
            frame_h = RW'(height_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 11'd768;
            low_reg    <= 11'd125;
            high_reg   <= 11'd225;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IDX_FRAME_WIDTH:    width_reg  <= cfg_data;
                CFG_IDX_FRAME_HEIGHT:   height_reg <= cfg_data;
                CFG_IDX_LOW_THRESHOLD:  low_reg    <= cfg_data;
                CFG_IDX_HIGH_THRESHOLD: high_reg   <= cfg_data;
                default:                high_reg   <= high_reg;
            endcase
        end
    end

    sobnms_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .frame_w   (frame_w),
        .frame_h   (frame_h),
        .resync    (resync),
        .hold      (clearing),
        .full      (full),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_col  (push_col),
        .push_mcol (push_mcol)
    );

    sobnms_fifo #(
        .DATA_W (DW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctl, push_col, push_mcol}),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_data),
        .empty     (empty)
    );

    assign head_ctl  = head_data[DW-1:2*AW];
    assign head_col  = head_data[2*AW-1:AW];
    assign head_mcol = head_data[AW-1:0];

    sobnms_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head_ctl  (head_ctl),
        .head_col  (head_col),
        .head_mcol (head_mcol),
        .pop       (pop),
        .clearing  (clearing),
        .low_thr   (low_reg),
        .high_thr  (high_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### bench/sobnms_checker.sv
// Edge result checker: follows the pixel stream, predicts each result word and compares it.
`timescale 1ns / 1ps
module sobnms_checker import sobnms_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_word_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_word_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   result_count
);

    localparam int MAXW = 1024;
    localparam int MAXH = 1024;

    logic [CFG_W-1:0] frame_w, frame_h, thr_low, thr_high;
    logic [PIX_W-1:0] pix_rows [2*MAXW];
    logic [MAG_W-1:0] mag_rows [2*MAXW];
    logic [SEC_W-1:0] sec_row  [MAXW];
    logic [PIX_W-1:0] pix_win  [9];
    logic [MAG_W-1:0] mag_win  [9];
    longint           raster_pos;
    logic [SEC_W-1:0] sec_hold;
    out_word_t        expected_edges [$];

    assign pending = expected_edges.size();

    function automatic longint clamp_size(input longint v, input longint hi);
        if (v < 3)
        begin
            return 3;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic int rounded_root(input longint s);
        longint f;
        f = 0;
        while ((f + 1) * (f + 1) <= s)
        begin
            f++;
        end
        if (s > f * f + f)
        begin
            f++;
        end
        return int'(f);
    endfunction

    function automatic logic [SEC_W-1:0] grad_sector(input int gx, input int gy);
        longint ax, ay, lhs;
        logic [SEC_W-1:0] diag;
        ax   = (gx < 0) ? -gx : gx;
        ay   = (gy < 0) ? -gy : gy;
        lhs  = ay * 65536;
        diag = ((gx >= 0) == (gy >= 0)) ? SEC_DIAG_POS : SEC_DIAG_NEG;
        if (ax == 0 && ay == 0)
        begin
            return SEC_HORZ;
        end
        if (gx >= 0)
        begin
            if (lhs < ax * 25815)
            begin
                return SEC_HORZ;
            end
            if (lhs < ax * 150722)
            begin
                return diag;
            end
            return SEC_VERT;
        end
        if (lhs <= ax * 28496)
        begin
            return SEC_HORZ;
        end
        if (lhs <= ax * 166373)
        begin
            return diag;
        end
        return SEC_VERT;
    endfunction

    task automatic predict_edge(input in_word_t word);
        longint wd, ht, n, lag, total, p, q1, q2, c, rr, cc;
        logic [PIX_W-1:0] v, top, mid;
        logic [MAG_W-1:0] mag, mtop, mmid, a, b, g;
        logic [SEC_W-1:0] sec, centre_sec;
        int gx, gy;
        out_word_t r;
        wd  = clamp_size(frame_w, MAXW);
        ht  = clamp_size(frame_h, MAXH);
        n   = wd * ht;
        lag = 2 * wd + 2;
        total = n + lag;
        p   = raster_pos;
        centre_sec = sec_hold;
        if (p >= total)
        begin
            p = 0;
        end
        q1 = p - wd - 1;
        q2 = p - lag;
        if (p < n)
        begin
            c   = p % wd;
            v   = word.action ? '0 : word.gray_pixel;
            top = pix_rows[MAXW + c];
            mid = pix_rows[c];
            pix_rows[MAXW + c] = mid;
            pix_rows[c] = v;
            for (int i = 0; i < 3; i++)
            begin
                pix_win[i*3]   = pix_win[i*3+1];
                pix_win[i*3+1] = pix_win[i*3+2];
            end
            pix_win[2] = top;
            pix_win[5] = mid;
            pix_win[8] = v;
        end
        if (q1 >= 0 && q1 < n)
        begin
            rr  = q1 / wd;
            cc  = q1 % wd;
            mag = '0;
            sec = SEC_HORZ;
            if (rr >= 1 && rr + 2 <= ht && cc >= 1 && cc + 2 <= wd)
            begin
                gx = (int'(pix_win[2]) - int'(pix_win[0]))
                   + 2 * (int'(pix_win[5]) - int'(pix_win[3]))
                   + (int'(pix_win[8]) - int'(pix_win[6]));
                gy = (int'(pix_win[6]) + 2 * int'(pix_win[7]) + int'(pix_win[8]))
                   - (int'(pix_win[0]) + 2 * int'(pix_win[1]) + int'(pix_win[2]));
                mag = MAG_W'(rounded_root(longint'(gx) * gx + longint'(gy) * gy));
                sec = grad_sector(gx, gy);
            end
            mtop = mag_rows[MAXW + cc];
            mmid = mag_rows[cc];
            mag_rows[MAXW + cc] = mmid;
            mag_rows[cc] = mag;
            for (int i = 0; i < 3; i++)
            begin
                mag_win[i*3]   = mag_win[i*3+1];
                mag_win[i*3+1] = mag_win[i*3+2];
            end
            mag_win[2] = mtop;
            mag_win[5] = mmid;
            mag_win[8] = mag;
            sec_hold = sec_row[cc];
            sec_row[cc] = sec;
        end
        if (q2 >= 0 && q2 < n)
        begin
            rr = q2 / wd;
            cc = q2 % wd;
            g  = '0;
            r.edge_peak = 1'b0;
            if (rr >= 1 && rr + 2 <= ht && cc >= 1 && cc + 2 <= wd)
            begin
                g = mag_win[4];
                case (centre_sec)
                    SEC_HORZ:     begin a = mag_win[3]; b = mag_win[5]; end
                    SEC_DIAG_POS: begin a = mag_win[2]; b = mag_win[6]; end
                    SEC_VERT:     begin a = mag_win[1]; b = mag_win[7]; end
                    default:      begin a = mag_win[0]; b = mag_win[8]; end
                endcase
                r.edge_peak = (g >= a && g >= b);
            end
            if (g >= thr_high)
            begin
                r.edge_class = CLASS_STRONG;
            end
            else if (g < thr_low)
            begin
                r.edge_class = CLASS_NONE;
            end
            else
            begin
                r.edge_class = CLASS_WEAK;
            end
            r.gradient_magnitude = g;
            r.frame_last = (q2 == n - 1);
            expected_edges.insert(expected_edges.size(), r);
        end
        raster_pos = (p + 1 >= total) ? 0 : p + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            frame_w  <= 11'd1024;
            frame_h  <= 11'd768;
            thr_low  <= 11'd125;
            thr_high <= 11'd225;
            for (int i = 0; i < 2*MAXW; i++)
            begin
                pix_rows[i] = '0;
                mag_rows[i] = '0;
            end
            for (int i = 0; i < MAXW; i++)
            begin
                sec_row[i] = '0;
            end
            for (int i = 0; i < 9; i++)
            begin
                pix_win[i] = '0;
                mag_win[i] = '0;
            end
            raster_pos = 0;
            sec_hold   = '0;
            expected_edges.delete();
            fail_count   <= 0;
            result_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IDX_FRAME_WIDTH:    frame_w  <= cfg_data;
                    CFG_IDX_FRAME_HEIGHT:   frame_h  <= cfg_data;
                    CFG_IDX_LOW_THRESHOLD:  thr_low  <= cfg_data;
                    CFG_IDX_HIGH_THRESHOLD: thr_high <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_edge(in_data);
            end
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (expected_edges.size() == 0)
                begin
                    $display("%0t: unexpected word peak=%0d class=%0d mag=%0d last=%0d",
                             $time, out_data.edge_peak, out_data.edge_class,
                             out_data.gradient_magnitude, out_data.frame_last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_edges.pop_front();
                    if (want.edge_peak !== out_data.edge_peak
                        || want.edge_class !== out_data.edge_class
                        || want.gradient_magnitude !== out_data.gradient_magnitude
                        || want.frame_last !== out_data.frame_last)
                    begin
                        $display("%0t: mismatch expected peak=%0d class=%0d mag=%0d last=%0d",
                                 $time, want.edge_peak, want.edge_class,
                                 want.gradient_magnitude, want.frame_last);
                        $display("%0t:          actual   peak=%0d class=%0d mag=%0d last=%0d",
                                 $time, out_data.edge_peak, out_data.edge_class,
                                 out_data.gradient_magnitude, out_data.frame_last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### bench/tb.sv
// Testbench top: drives pixel and register traffic into the edge unit and gives the verdict.
`timescale 1ns / 1ps
module tb;
    import sobnms_pkg::*;

    localparam int PHASES = 6;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_word_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   result_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    longint               cycles;
    int                   words_sent;

    int ph_width [PHASES] = '{3, 0, 5, 7, 2047, 4};
    int ph_height[PHASES] = '{3, 0, 4, 3, 3, 2047};
    int ph_low   [PHASES] = '{0, 2047, 30, 100, 125, 500};
    int ph_high  [PHASES] = '{0, 2047, 200, 50, 225, 1443};
    int ph_words [PHASES] = '{25, 40, 260, 260, 60, 260};
    int ph_sidle [PHASES] = '{6, 6, 6, 75, 75, 0};
    int ph_ridle [PHASES] = '{75, 75, 75, 6, 6, 0};

    sobel_nms_double_threshold_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sobnms_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input in_word_t word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= word;
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (200) @(posedge clk);
    endtask

    function automatic in_word_t random_word();
        in_word_t word;
        int pick;
        word.action = ($urandom_range(9) == 0);
        pick = $urandom_range(9);
        if (pick < 3)
        begin
            word.gray_pixel = 8'd0;
        end
        else if (pick < 6)
        begin
            word.gray_pixel = 8'd255;
        end
        else
        begin
            word.gray_pixel = $urandom_range(255);
        end
        return word;
    endfunction

    initial
    begin
        in_word_t word;
        cycles        = 0;
        words_sent    = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct = ph_sidle[ph];
            recv_idle_pct = ph_ridle[ph];
            write_reg(CFG_IDX_FRAME_WIDTH, ph_width[ph]);
            write_reg(CFG_IDX_FRAME_HEIGHT, ph_height[ph]);
            write_reg(CFG_IDX_LOW_THRESHOLD, ph_low[ph]);
            write_reg(CFG_IDX_HIGH_THRESHOLD, ph_high[ph]);
            for (int k = 0; k < ph_words[ph]; k++)
            begin
                if (ph == 0)
                begin
                    word.action     = (k % 7 == 6);
                    word.gray_pixel = (k % 3 == 0) ? 8'd255 : ((k % 5 == 1) ? 8'd0 : 8'(k * 37));
                end
                else
                begin
                    word = random_word();
                end
                if (ph == 2 && k == ph_words[ph] / 2)
                begin
                    settle();
                end
                send_word(word);
            end
            settle();
        end
        $display("Sent %0d words over %0d register settings; %0d result words checked.",
                 words_sent, PHASES, result_count);
        $display("Covered clamped sizes, threshold extremes, drain ticks and stalls on both sides.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches, %0d words never arrived", fail_count, pending);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
